>>> sv/bigram_table_codec_top_macros.svh
// Assertion macros for the bigram table codec.
// Used by bigram_table_codec_top; the macros expect clk and rst_n in scope.
`ifndef BIGRAM_TABLE_CODEC_TOP_MACROS_SVH
`define BIGRAM_TABLE_CODEC_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, checked outside reset
`define BGC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication, checked outside reset
`define BGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset
`define BGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BGC_ASSERT(lbl, prop, msg)
`define BGC_ASSERT_IMP(lbl, ante, cons, msg)
`define BGC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/bgc_pkg.sv
// Shared types and constants of the bigram table codec.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bgc_pkg;

  // Fixed field widths
  localparam int IDX_W  = 7;
  localparam int PAIR_W = 16;
  localparam int LEN_W  = 16;

  // Item kinds
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_ENC  = 2'd1;
  localparam logic [1:0] KIND_DEC  = 2'd2;

  localparam logic [7:0]       CODE_BASE   = 8'h80;
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd256;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  // Table write port
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [PAIR_W-1:0] pair;
  } wr_t;

  // Token travelling down the chain of cells
  typedef struct packed {
    logic              vld;
    logic              enc;   // 1: pair search, 0: code lookup
    logic [PAIR_W-1:0] key;   // pair, or code index in the low bits
    logic              done;  // search settled
    logic              hit;
    logic [IDX_W-1:0]  idx;
    logic [PAIR_W-1:0] data;  // looked-up pair
  } tok_t;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } res_t;

  // Up to two results pushed at once
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

>>> sv/bgc_cell.sv
// One table cell: holds one pair and advances the search token by one place.
// Depends on bgc_pkg.
`timescale 1ns / 1ps

module bgc_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  bgc_pkg::wr_t  wr,
  input  bgc_pkg::tok_t tok_in,
  output bgc_pkg::tok_t tok_out
);
  import bgc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [PAIR_W-1:0] entry_r;
  tok_t              tok_r;
  tok_t              tok_nxt;

  // Table entry, written by load beats
  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MY_IDX) begin
      entry_r <= wr.pair;
    end
  end

  // Compare or capture against this entry
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.enc) begin
      if (!tok_in.done) begin
        if (entry_r == tok_in.key) begin
          tok_nxt.done = 1'b1;
          tok_nxt.hit  = 1'b1;
          tok_nxt.idx  = MY_IDX;
        end else if (entry_r > tok_in.key) begin
          tok_nxt.done = 1'b1;
        end
      end
    end else if (tok_in.key[IDX_W-1:0] == MY_IDX) begin
      tok_nxt.data = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

>>> sv/bgc_chain.sv
// Row of table cells; the token moves one cell per cycle.
// Depends on bgc_pkg and bgc_cell.
`timescale 1ns / 1ps

module bgc_chain #(
  parameter int N = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  bgc_pkg::wr_t  wr,
  input  bgc_pkg::tok_t tok_in,
  output bgc_pkg::tok_t tok_out
);
  import bgc_pkg::*;

  tok_t link [0:N];

  assign link[0] = tok_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bgc_cell #(.CELL_IDX(i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

  assign tok_out = link[N];

endmodule

>>> sv/bgc_outq.sv
// Result queue: takes up to two beats a cycle, hands one a cycle downstream while out_stall is low.
// Depends on bgc_pkg.
`timescale 1ns / 1ps

module bgc_outq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bgc_pkg::push_t                  push,
  output logic                            out_valid,
  input  logic                            out_stall,
  output bgc_pkg::res_t                   head,
  output logic [bgc_pkg::OQ_CNT_W-1:0]    level
);
  import bgc_pkg::*;

  res_t                mem_r [0:OQ_DEPTH-1];
  logic [OQ_PTR_W-1:0] wr_ptr_r;
  logic [OQ_PTR_W-1:0] rd_ptr_r;
  logic [OQ_CNT_W-1:0] cnt_r;
  logic [OQ_CNT_W-1:0] cnt_nxt;
  logic                pop;

  assign pop       = (cnt_r != '0) && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign level     = cnt_r;
  assign cnt_nxt   = cnt_r + OQ_CNT_W'(push.cnt) - OQ_CNT_W'(pop);

  // Storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + OQ_PTR_W'(1)] <= push.r1;
    end
  end

  // Pointers and fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + OQ_PTR_W'(push.cnt);
      rd_ptr_r <= rd_ptr_r + OQ_PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> sv/bigram_table_codec_top.sv
// Top level of the bigram table codec: control, pending byte, decode budget.
// Depends on bgc_pkg, bgc_chain, bgc_outq and the assertion macro header.
`timescale 1ns / 1ps
`include "bigram_table_codec_top_macros.svh"

// Bigram table codec.
// Input channel in_*: one beat is a load (writes a table entry, no result),
// an encode byte or a decode byte; in_last closes a string. Result channel
// out_*: byte, has_byte flag and end_of_string, up to two beats per item.
// cfg_wr_en/cfg_wr_data set the decoder length limit (reset 256) and reload
// the decode budget; write it only while the block is idle.
// Sequence: a load is written while idle. An encode byte with no pending
// byte, a plain decode byte, or one past the limit goes from idle to the
// resolve state. An encode byte with a pending byte, or a decode code, sends
// a token through the TABLE_ENTRIES cells one cell per cycle, then resolves.
// One item is in work at a time; a new item is taken when the block is idle
// and the result queue (four beats) has room for two.
// Reset clears pending byte, budget, queue and token; the table keeps its
// contents and must be loaded before use. A stall on out_stall holds the
// head beat; in_stall rises once the queue holds more than two beats.
module bigram_table_codec_top #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_kind,
  input  logic [7:0]                  in_data_byte,
  input  logic [bgc_pkg::IDX_W-1:0]   in_table_index,
  input  logic [bgc_pkg::PAIR_W-1:0]  in_table_pair,
  input  logic                        in_last,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_has_byte,
  output logic                        out_end_of_string,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [bgc_pkg::LEN_W-1:0]   cfg_wr_data
);
  import bgc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_SCAN    = 3'b010,
    S_RESOLVE = 3'b100
  } state_t;

  state_t              state_r;
  state_t              state_nxt;

  logic [1:0]          kind_r;
  logic [7:0]          byte_r;
  logic                last_r;

  logic [7:0]          pend_byte_r;
  logic [7:0]          pend_byte_nxt;
  logic                pend_vld_r;
  logic                pend_vld_nxt;
  logic [LEN_W-1:0]    max_len_r;
  logic [LEN_W-1:0]    rem_r;
  logic [LEN_W-1:0]    rem_nxt;

  logic                scan_hit_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [PAIR_W-1:0]   scan_data_r;

  logic                accept;
  logic                need_scan;
  logic                is_enc;
  wr_t                 wr;
  tok_t                tok_in;
  tok_t                tok_out;
  push_t               push;
  res_t                head;
  logic [OQ_CNT_W-1:0] oq_level;

  // Input handshake
  assign in_stall = !((state_r == S_IDLE) && (oq_level <= OQ_CNT_W'(2)));
  assign accept   = in_valid && !in_stall;
  assign is_enc   = (in_kind == KIND_ENC);

  // Items that need the table
  always_comb begin
    need_scan = 1'b0;
    unique case (in_kind)
      KIND_ENC: need_scan = pend_vld_r;
      KIND_DEC: need_scan = (rem_r > LEN_W'(1)) && in_data_byte[7];
      default:  need_scan = 1'b0;
    endcase
  end

  // Table write and token launch
  assign wr.en   = accept && (in_kind == KIND_LOAD);
  assign wr.idx  = in_table_index;
  assign wr.pair = in_table_pair;

  always_comb begin
    tok_in      = '0;
    tok_in.vld  = accept && need_scan;
    tok_in.enc  = is_enc;
    tok_in.key  = is_enc ? {pend_byte_r, in_data_byte}
                         : {{(PAIR_W-IDX_W){1'b0}}, in_data_byte[IDX_W-1:0]};
  end

  bgc_chain #(.N(TABLE_ENTRIES)) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .tok_in  (tok_in),
    .tok_out (tok_out)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == KIND_ENC || in_kind == KIND_DEC)) begin
          state_nxt = need_scan ? S_SCAN : S_RESOLVE;
        end
      end
      S_SCAN: begin
        if (tok_out.vld) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Work out the results of the item in hand
  always_comb begin
    push          = '0;
    pend_byte_nxt = pend_byte_r;
    pend_vld_nxt  = pend_vld_r;
    rem_nxt       = rem_r;
    if (state_r == S_RESOLVE) begin
      unique case (kind_r)
        KIND_ENC: begin
          if (pend_vld_r && scan_hit_r) begin
            // pair found: one code byte
            push.cnt     = 2'd1;
            push.r0      = '{data: CODE_BASE | {1'b0, scan_idx_r}, has: 1'b1, eos: last_r};
            pend_vld_nxt = 1'b0;
            if (last_r) begin
              pend_byte_nxt = '0;
            end
          end else if (pend_vld_r) begin
            // no pair: pending byte out, new byte held (or sent too at end of string)
            push.cnt = 2'd1;
            push.r0  = '{data: pend_byte_r, has: 1'b1, eos: 1'b0};
            if (last_r) begin
              push.cnt      = 2'd2;
              push.r1       = '{data: byte_r, has: 1'b1, eos: 1'b1};
              pend_vld_nxt  = 1'b0;
              pend_byte_nxt = '0;
            end else begin
              pend_byte_nxt = byte_r;
            end
          end else if (last_r) begin
            push.cnt      = 2'd1;
            push.r0       = '{data: byte_r, has: 1'b1, eos: 1'b1};
            pend_byte_nxt = '0;
          end else begin
            pend_byte_nxt = byte_r;
            pend_vld_nxt  = 1'b1;
          end
        end
        KIND_DEC: begin
          if (rem_r > LEN_W'(1)) begin
            if (byte_r[7]) begin
              push.cnt = 2'd1;
              push.r0  = '{data: scan_data_r[15:8], has: 1'b1, eos: 1'b0};
              if (rem_r > LEN_W'(2)) begin
                push.cnt = 2'd2;
                push.r1  = '{data: scan_data_r[7:0], has: 1'b1, eos: 1'b0};
                rem_nxt  = rem_r - LEN_W'(2);
              end else begin
                rem_nxt  = rem_r - LEN_W'(1);
              end
            end else begin
              push.cnt = 2'd1;
              push.r0  = '{data: byte_r, has: 1'b1, eos: 1'b0};
              rem_nxt  = rem_r - LEN_W'(1);
            end
          end
          // close the string; bare end marker if nothing came out
          if (last_r) begin
            rem_nxt = max_len_r;
            unique case (push.cnt)
              2'd0: begin
                push.cnt = 2'd1;
                push.r0  = '{data: 8'h00, has: 1'b0, eos: 1'b1};
              end
              2'd1:    push.r0.eos = 1'b1;
              default: push.r1.eos = 1'b1;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_byte_r <= '0;
      pend_vld_r  <= 1'b0;
      max_len_r   <= MAX_LEN_RST;
      rem_r       <= MAX_LEN_RST;
    end else begin
      state_r     <= state_nxt;
      pend_byte_r <= pend_byte_nxt;
      pend_vld_r  <= pend_vld_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
        rem_r     <= cfg_wr_data;
      end else begin
        rem_r     <= rem_nxt;
      end
    end
  end

  // Item and search result holding
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      byte_r <= in_data_byte;
      last_r <= in_last;
    end
    if (tok_out.vld) begin
      scan_hit_r  <= tok_out.hit;
      scan_idx_r  <= tok_out.idx;
      scan_data_r <= tok_out.data;
    end
  end

  bgc_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head),
    .level     (oq_level)
  );

  assign out_byte          = head.data;
  assign out_has_byte      = head.has;
  assign out_end_of_string = head.eos;

  // Checks
  `BGC_ASSERT_IMP(a_tok_only_in_scan, tok_out.vld, state_r == S_SCAN, "token left chain outside scan")
  `BGC_ASSERT(a_oq_no_overflow, oq_level <= OQ_CNT_W'(OQ_DEPTH), "result queue overflow")
  `BGC_ASSERT_NXT(a_enc_last_clears, (state_r == S_RESOLVE) && (kind_r == KIND_ENC) && last_r, !pend_vld_r, "pending byte kept past end of string")

endmodule

>>> dv/bigram_table_codec_top_test.sv
// Self-checking testbench for bigram_table_codec_top: pair encoder, pair decoder and table loads.
// Depends on bgc_pkg and the RTL of the block; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module bigram_table_codec_top_test;
  import bgc_pkg::*;

  localparam int ENTRIES     = 128;
  localparam int ITEMS       = 1000;
  localparam int PHASES      = 8;
  // three full table loads count towards the item total
  localparam int RAND_ITEMS  = (ITEMS - 3 * ENTRIES) / PHASES;
  localparam int SETTLE      = ENTRIES + 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int N_CHARS     = 12;
  // kind left unused by the block; it must be dropped
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Predictor of the codec and store of the beats it still owes
  class codec_scoreboard;
    logic [15:0] pairs [ENTRIES];
    logic [7:0]  pend_byte;
    logic        pend_vld;
    logic [15:0] len_limit;
    logic [15:0] dec_left;
    res_t        owed [$];
    int unsigned errors, items_seen, beats_checked, codes_made, bare_ends;

    function new();
      pend_byte = '0;
      pend_vld  = 1'b0;
      len_limit = MAX_LEN_RST;
      dec_left  = MAX_LEN_RST;
      errors = 0; items_seen = 0; beats_checked = 0; codes_made = 0; bare_ends = 0;
    endfunction

    task report(string what);
      if (errors < 100) $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    function void set_limit(logic [15:0] v);
      len_limit = v;
      dec_left  = v;
    endfunction

    // first equal entry, or -1 at the first greater entry or the end
    function int find_entry(logic [15:0] key);
      for (int i = 0; i < ENTRIES; i++) begin
        if (pairs[i] == key) return i;
        if (pairs[i] > key) return -1;
      end
      return -1;
    endfunction

    function void owe(logic [7:0] d, logic has);
      res_t r;
      r.data = d;
      r.has  = has;
      r.eos  = 1'b0;
      owed.push_back(r);
    endfunction

    function void close_string();
      res_t r;
      r = owed.pop_back();
      r.eos = 1'b1;
      owed.push_back(r);
    endfunction

    // one accepted input beat
    function void note_input(logic [1:0] kind, logic [7:0] b, logic [IDX_W-1:0] idx,
                             logic [15:0] pair, logic last);
      int          hit;
      logic        keep_new;
      int unsigned start;
      logic [15:0] p;
      start = owed.size();
      case (kind)
        KIND_LOAD: begin
          items_seen++;
          if (int'(idx) < ENTRIES) pairs[idx] = pair;
        end
        KIND_ENC: begin
          items_seen++;
          keep_new = 1'b1;
          if (pend_vld) begin
            hit = find_entry({pend_byte, b});
            if (hit >= 0) begin
              owe(CODE_BASE | 8'(hit), 1'b1);
              codes_made++;
              pend_vld = 1'b0;
              keep_new = 1'b0;
            end else begin
              owe(pend_byte, 1'b1);
            end
          end
          if (keep_new) begin
            pend_byte = b;
            pend_vld  = 1'b1;
          end
          if (last) begin
            if (pend_vld) owe(pend_byte, 1'b1);
            pend_vld  = 1'b0;
            pend_byte = '0;
            close_string();
          end
        end
        KIND_DEC: begin
          items_seen++;
          if (dec_left > 16'd1) begin
            if (b >= CODE_BASE) begin
              p = (int'(b[6:0]) < ENTRIES) ? pairs[b[6:0]] : 16'h0000;
              owe(p[15:8], 1'b1);
              dec_left--;
              if (dec_left > 16'd1) begin
                owe(p[7:0], 1'b1);
                dec_left--;
              end
            end else begin
              owe(b, 1'b1);
              dec_left--;
            end
          end
          if (last) begin
            if (owed.size() == start) begin
              owe(8'h00, 1'b0);
              bare_ends++;
            end
            close_string();
            dec_left = len_limit;
          end
        end
        default: ;
      endcase
    endfunction

    // one accepted result beat against the oldest owed one
    task check_result(logic [7:0] b, logic has, logic eos);
      res_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected beat byte %02h has %0d eos %0d", b, has, eos));
        return;
      end
      want = owed.pop_front();
      beats_checked++;
      if (b !== want.data) report($sformatf("byte %02h, expected %02h", b, want.data));
      if (has !== want.has) report($sformatf("has_byte %0d, expected %0d", has, want.has));
      if (eos !== want.eos) report($sformatf("end_of_string %0d, expected %0d", eos, want.eos));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_kind = KIND_LOAD;
  logic [7:0]        in_data_byte = '0;
  logic [IDX_W-1:0]  in_table_index = '0;
  logic [PAIR_W-1:0] in_table_pair = '0;
  logic              in_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              out_has_byte;
  logic              out_end_of_string;
  logic              cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data = '0;

  codec_scoreboard sb = new();

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stim_items = 0;
  int unsigned limits_set = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] tbl_img [ENTRIES];
  logic [7:0]  chars [N_CHARS];

  int unsigned ph_limit [PHASES] = '{256, 65535, 1, 2, 3, 7, 16, 256};
  int unsigned ph_idle  [PHASES] = '{0, 78, 0, 23, 0, 78, 0, 23};
  int unsigned ph_stall [PHASES] = '{0, 0, 78, 23, 0, 0, 78, 23};

  bigram_table_codec_top #(
    .TABLE_ENTRIES (ENTRIES)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_table_index    (in_table_index),
    .in_table_pair     (in_table_pair),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_end_of_string (out_end_of_string),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // beats seen on both channels feed the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(in_kind, in_data_byte, in_table_index, in_table_pair, in_last);
      if (out_valid && !out_stall)
        sb.check_result(out_byte, out_has_byte, out_end_of_string);
    end
  end

  // watchdog: too long with no beat anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
        $display("bigram_table_codec_top_test: errors");
        $finish;
      end
    end
  end

  // present one beat after a random gap and hold it until taken
  task automatic send_item(logic [1:0] kind, logic [7:0] b, logic [IDX_W-1:0] idx,
                           logic [15:0] pair, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_data_byte   <= b;
    in_table_index <= idx;
    in_table_pair  <= pair;
    in_last        <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (kind != KIND_SPARE) stim_items++;
  endtask

  task automatic send_enc(logic [7:0] b, logic last);
    send_item(KIND_ENC, b, IDX_W'($urandom_range(127)), 16'($urandom_range(16'hFFFF)), last);
  endtask

  task automatic send_dec(logic [7:0] b, logic last);
    send_item(KIND_DEC, b, IDX_W'($urandom_range(127)), 16'($urandom_range(16'hFFFF)), last);
  endtask

  task automatic send_load(int unsigned idx, logic [15:0] pair);
    tbl_img[idx] = pair;
    send_item(KIND_LOAD, 8'($urandom_range(255)), IDX_W'(idx), pair, 1'($urandom_range(1)));
  endtask

  // valid drops, then wait for every owed beat; the first edge lets the
  // monitor take the last accepted beat
  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    sb.set_limit(v);
    limits_set++;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    if ($urandom_range(99) < 85) return chars[$urandom_range(N_CHARS-1)];
    return 8'($urandom_range(255));
  endfunction

  // full table from a small character set, sorted or in random order
  task automatic load_table(bit sorted);
    logic [15:0] q [$];
    int unsigned order [$];
    for (int i = 0; i < N_CHARS; i++) chars[i] = 8'($urandom_range(255));
    chars[0] = 8'h00;
    chars[1] = 8'hFF;
    for (int i = 0; i < ENTRIES; i++) begin
      q.push_back({chars[$urandom_range(N_CHARS-1)], chars[$urandom_range(N_CHARS-1)]});
      order.push_back(i);
    end
    q[0] = 16'h0000;
    q[1] = 16'hFFFF;
    if (sorted) q.sort();
    else q.shuffle();
    order.shuffle();
    foreach (order[k]) send_load(order[k], q[order[k]]);
  endtask

  // text built mostly from table pairs so the encoder finds codes
  task automatic send_text(int unsigned len, bit closed);
    logic [7:0] txt [$];
    int unsigned e;
    while (txt.size() < len) begin
      if ($urandom_range(99) < 55) begin
        e = $urandom_range(ENTRIES-1);
        txt.push_back(tbl_img[e][15:8]);
        txt.push_back(tbl_img[e][7:0]);
      end else begin
        txt.push_back(pick_char());
      end
    end
    foreach (txt[i]) send_enc(txt[i], closed && (i == txt.size() - 1));
  endtask

  // half codes, half plain bytes
  task automatic send_codes(int unsigned len, bit closed);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(1)) b = CODE_BASE | 8'($urandom_range(ENTRIES-1));
      else b = 8'($urandom_range(127));
      send_dec(b, closed && (i == len - 1));
    end
  endtask

  task automatic directed_items();
    // pair found: the code closes the string
    send_enc(tbl_img[5][15:8], 1'b0);
    send_enc(tbl_img[5][7:0], 1'b1);
    // lone zero byte
    send_enc(8'h00, 1'b1);
    // likely miss: pending and new byte both go out
    send_enc(8'hFF, 1'b0);
    send_enc(8'h01, 1'b1);
    // top entry, then a trailing byte
    send_enc(tbl_img[ENTRIES-1][15:8], 1'b0);
    send_enc(tbl_img[ENTRIES-1][7:0], 1'b0);
    send_enc(8'h41, 1'b1);
    // pending byte survives a decode string
    send_enc(8'h7F, 1'b0);
    send_dec(CODE_BASE, 1'b1);
    send_enc(8'h80, 1'b1);
    // decode extremes
    send_dec(8'hFF, 1'b0);
    send_dec(8'h00, 1'b0);
    send_dec(8'h7F, 1'b0);
    send_dec(8'h01, 1'b1);
    // unused kind is dropped
    send_item(KIND_SPARE, 8'hFF, '1, 16'hFFFF, 1'b1);
    // reload mid-stream, then read it back both ways
    send_load(3, 16'hFFFF);
    send_dec(CODE_BASE | 8'd3, 1'b1);
    send_enc(8'hFF, 1'b0);
    send_enc(8'hFF, 1'b1);
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned goal, halfway, pick;
    bit paused;
    goal    = stim_items + n;
    halfway = stim_items + n / 2;
    paused  = 1'b0;
    while (stim_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        send_text($urandom_range(1, 10), 1'b1);
      end else if (pick < 76) begin
        send_codes($urandom_range(1, 12), 1'b1);
      end else if (pick < 86) begin
        // open text string interleaved with decode beats
        send_text($urandom_range(1, 3), 1'b0);
        send_codes($urandom_range(1, 4), 1'($urandom_range(1)));
      end else if (pick < 94) begin
        send_load($urandom_range(ENTRIES-1), 16'($urandom_range(16'hFFFF)));
      end else begin
        send_item(KIND_SPARE, 8'($urandom_range(255)), IDX_W'($urandom_range(127)),
                  16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
      end
      // sender holds off until the block has caught up
      if (!paused && stim_items >= halfway) begin
        paused = 1'b1;
        wait_results();
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_table(1'b1);
    directed_items();
    for (int p = 0; p < PHASES; p++) begin
      idle_pct  = ph_idle[p];
      stall_pct = ph_stall[p];
      if (p != 0) begin
        wait_results();
        repeat (SETTLE) @(posedge clk);
        write_limit(16'(ph_limit[p]));
        if (p == 4) load_table(1'b0);
        else if (p == 6) load_table(1'b1);
      end
      random_phase(RAND_ITEMS);
    end
    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d owed beats never arrived", sb.owed.size()));
    $display("run covered %0d items and %0d result beats under %0d written length limits",
             sb.items_seen, sb.beats_checked, limits_set);
    $display("encoder produced %0d pair codes; decoder gave %0d bare end markers",
             sb.codes_made, sb.bare_ends);
    if (sb.errors == 0) begin
      $display("bigram_table_codec_top_test: clean");
    end else begin
      $display("bigram_table_codec_top_test: errors");
    end
    $finish;
  end

endmodule

>>> bigram_table_codec_top.f
+incdir+sv
sv/bgc_pkg.sv
sv/bgc_cell.sv
sv/bgc_chain.sv
sv/bgc_outq.sv
sv/bigram_table_codec_top.sv
dv/bigram_table_codec_top_test.sv
